/* hdl/rxr_pkg.sv */
package rxr_pkg;

    localparam int RING_SIZE = 256;
    localparam int PTR_W     = $clog2(RING_SIZE);
    localparam int LEN_W     = 14;
    localparam int CNT_W     = 32;
    localparam int OP_W      = 2;
    localparam int POST_W    = 8;
    localparam int KIND_W    = 3;
    localparam int SLOT_W    = 8;

    // Stored entry: done mark above the length
    localparam int ENTRY_W   = LEN_W + 1;

    localparam logic [LEN_W-1:0] BUF_SIZE_RESET = LEN_W'(2048);

    localparam logic [OP_W-1:0] OP_DELIVER = 2'd0;
    localparam logic [OP_W-1:0] OP_POST    = 2'd1;
    localparam logic [OP_W-1:0] OP_HARVEST = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_DELIVERED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POSTED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HARVESTED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd4;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Request from the control logic to the descriptor store
    typedef struct packed {
        logic rd_en;
        ptr_t rd_addr;
        logic wr_en;
        ptr_t wr_addr;
        logic wr_done;
        len_t wr_len;
    } slot_req_t;

    // Registered read answer from the descriptor store
    typedef struct packed {
        logic done;
        len_t len;
    } slot_rsp_t;

endpackage

/* hdl/rxr_in_if.sv */
interface rxr_in_if;
    logic                           valid;
    logic                           ready;
    logic [rxr_pkg::OP_W-1:0]       op;
    logic [rxr_pkg::LEN_W-1:0]      frame_length;
    logic [rxr_pkg::POST_W-1:0]     post_count;

    modport source (output valid, output op, output frame_length, output post_count,
                    input ready);
    modport sink   (input valid, input op, input frame_length, input post_count,
                    output ready);
endinterface

/* hdl/rxr_out_if.sv */
interface rxr_out_if;
    logic                           valid;
    logic                           ready;
    logic [rxr_pkg::KIND_W-1:0]     result_kind;
    logic [rxr_pkg::SLOT_W-1:0]     slot_index;
    logic [rxr_pkg::LEN_W-1:0]      length_out;
    logic                           checksum_valid;
    logic                           rx_interrupt;
    logic [rxr_pkg::CNT_W-1:0]      dropped_total;
    logic [rxr_pkg::CNT_W-1:0]      packets_total;
    logic [rxr_pkg::CNT_W-1:0]      bytes_total;

    modport source (output valid, output result_kind, output slot_index, output length_out,
                    output checksum_valid, output rx_interrupt, output dropped_total,
                    output packets_total, output bytes_total, input ready);
    modport sink   (input valid, input result_kind, input slot_index, input length_out,
                    input checksum_valid, input rx_interrupt, input dropped_total,
                    input packets_total, input bytes_total, output ready);
endinterface

/* hdl/rxr_ram.sv */
module rxr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/rxr_slot_store.sv */
// Descriptor slots: length and done mark in one RAM, plus a written flag per
// slot so that unwritten slots read as not done after reset.
module rxr_slot_store (
    input  logic                clk,
    input  logic                rst_n,
    input  rxr_pkg::slot_req_t  req,
    output rxr_pkg::slot_rsp_t  rsp
);

    logic [rxr_pkg::ENTRY_W-1:0] rdata;
    logic [rxr_pkg::RING_SIZE-1:0] written_reg;
    logic                          rd_written_reg;

    rxr_ram #(
        .WIDTH (rxr_pkg::ENTRY_W),
        .DEPTH (rxr_pkg::RING_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.wr_addr),
        .wdata ({req.wr_done, req.wr_len}),
        .re    (req.rd_en),
        .raddr (req.rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_addr];
            end
        end
    end

    assign rsp.done = rd_written_reg & rdata[rxr_pkg::LEN_W];
    assign rsp.len  = rdata[rxr_pkg::LEN_W-1:0];

endmodule

/* hdl/rx_descriptor_ring.sv */
// Channel   Direction  Payload
// req       in         op, frame_length, post_count
// rsp       out        result_kind, slot_index, length_out, checksum_valid,
//                      rx_interrupt, dropped_total, packets_total, bytes_total
// cfg       in         cfg_we, cfg_wdata (buffer_size)
//
// Each item passes through accept and then execute, in which the slot read
// issued at accept returns and the slot is written back.
// One item is in flight at a time; req.ready is high only while idle.
// Execute waits while the output register holds a result not yet taken;
// an op 3 item finishes without a result.
// Reset is asynchronous; no clearing pass, per-slot written flags clear at once.
module rx_descriptor_ring (
    input  logic                      clk,
    input  logic                      rst_n,
    rxr_in_if.sink                    req,
    rxr_out_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [rxr_pkg::LEN_W-1:0] cfg_wdata
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                       state_reg;
    logic [rxr_pkg::LEN_W-1:0]    buf_size_reg;

    // Item held during execute
    logic [rxr_pkg::OP_W-1:0]     op_reg;
    rxr_pkg::len_t                flen_reg;
    logic [rxr_pkg::POST_W-1:0]   pcnt_reg;

    // Ring pointers and statistics
    rxr_pkg::ptr_t                head_reg,  head_next;
    rxr_pkg::ptr_t                tail_reg,  tail_next;
    rxr_pkg::ptr_t                clean_reg, clean_next;
    rxr_pkg::cnt_t                drop_reg,  drop_next;
    rxr_pkg::cnt_t                pkt_reg,   pkt_next;
    rxr_pkg::cnt_t                byte_reg,  byte_next;

    // Output register
    logic                         out_valid_reg;
    logic [rxr_pkg::KIND_W-1:0]   kind_reg,  kind_next;
    logic [rxr_pkg::SLOT_W-1:0]   slot_reg,  slot_next;
    rxr_pkg::len_t                len_reg,   len_next;
    logic                         csum_reg,  csum_next;
    logic                         irq_reg,   irq_next;

    rxr_pkg::slot_req_t           store_req;
    rxr_pkg::slot_rsp_t           store_rsp;

    logic                         accept;
    logic                         exec_fire;
    logic                         emits;
    rxr_pkg::len_t                clamp_len;
    logic [rxr_pkg::PTR_W:0]      head_inc;
    logic [rxr_pkg::PTR_W:0]      clean_inc;
    logic [rxr_pkg::PTR_W+rxr_pkg::POST_W:0] tail_sum;

    rxr_slot_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .rsp   (store_rsp)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Every op but the unused code leaves a result, so it needs a free output slot
    assign emits     = (op_reg != rxr_pkg::OP_UNUSED);
    assign exec_fire = (state_reg == ST_EXEC) && (!emits || !out_valid_reg || rsp.ready);

    assign clamp_len = (flen_reg > buf_size_reg) ? buf_size_reg : flen_reg;

    // Pointer arithmetic modulo the ring size
    assign head_inc  = {1'b0, head_reg} + (rxr_pkg::PTR_W+1)'(1);
    assign clean_inc = {1'b0, clean_reg} + (rxr_pkg::PTR_W+1)'(1);
    assign tail_sum  = (rxr_pkg::PTR_W+rxr_pkg::POST_W+1)'(tail_reg)
                     + (rxr_pkg::PTR_W+rxr_pkg::POST_W+1)'(pcnt_reg);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        clean_next = clean_reg;
        drop_next  = drop_reg;
        pkt_next   = pkt_reg;
        byte_next  = byte_reg;
        kind_next  = rxr_pkg::KIND_EMPTY;
        slot_next  = rxr_pkg::SLOT_W'(clean_reg);
        len_next   = '0;
        csum_next  = 1'b0;
        irq_next   = 1'b0;

        store_req.rd_en   = accept && (req.op == rxr_pkg::OP_HARVEST);
        store_req.rd_addr = clean_reg;
        store_req.wr_en   = 1'b0;
        store_req.wr_addr = head_reg;
        store_req.wr_done = 1'b1;
        store_req.wr_len  = clamp_len;

        unique case (op_reg)
            rxr_pkg::OP_DELIVER:
            begin
                slot_next = rxr_pkg::SLOT_W'(head_reg);
                if (head_reg == tail_reg)
                begin
                    // No posted buffer: drop and count
                    drop_next = drop_reg + rxr_pkg::CNT_W'(1);
                    kind_next = rxr_pkg::KIND_DROPPED;
                end
                else
                begin
                    store_req.wr_en = exec_fire;
                    head_next       = rxr_pkg::ptr_t'(head_inc % rxr_pkg::RING_SIZE);
                    kind_next       = rxr_pkg::KIND_DELIVERED;
                    len_next        = clamp_len;
                    csum_next       = 1'b1;
                    irq_next        = 1'b1;
                end
            end
            rxr_pkg::OP_POST:
            begin
                tail_next = rxr_pkg::ptr_t'(tail_sum % rxr_pkg::RING_SIZE);
                kind_next = rxr_pkg::KIND_POSTED;
                slot_next = rxr_pkg::SLOT_W'(tail_next);
            end
            rxr_pkg::OP_HARVEST:
            begin
                store_req.wr_addr = clean_reg;
                store_req.wr_done = 1'b0;
                store_req.wr_len  = store_rsp.len;
                if (store_rsp.done)
                begin
                    // Write back with the done mark cleared
                    store_req.wr_en = exec_fire;
                    clean_next      = rxr_pkg::ptr_t'(clean_inc % rxr_pkg::RING_SIZE);
                    pkt_next        = pkt_reg + rxr_pkg::CNT_W'(1);
                    byte_next       = byte_reg + rxr_pkg::CNT_W'(store_rsp.len);
                    kind_next       = rxr_pkg::KIND_HARVESTED;
                    len_next        = store_rsp.len;
                    csum_next       = 1'b1;
                end
            end
            rxr_pkg::OP_UNUSED:
            begin
                // Accepted and discarded
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            buf_size_reg  <= rxr_pkg::BUF_SIZE_RESET;
            op_reg        <= rxr_pkg::OP_UNUSED;
            flen_reg      <= '0;
            pcnt_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            clean_reg     <= '0;
            drop_reg      <= '0;
            pkt_reg       <= '0;
            byte_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= '0;
            slot_reg      <= '0;
            len_reg       <= '0;
            csum_reg      <= 1'b0;
            irq_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                buf_size_reg <= cfg_wdata;
            end

            // Taken result empties the register unless a new one lands this cycle
            if (rsp.valid && rsp.ready && !(exec_fire && emits))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= req.op;
                        flen_reg  <= req.frame_length;
                        pcnt_reg  <= req.post_count;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (exec_fire)
                    begin
                        state_reg <= ST_IDLE;
                        head_reg  <= head_next;
                        tail_reg  <= tail_next;
                        clean_reg <= clean_next;
                        drop_reg  <= drop_next;
                        pkt_reg   <= pkt_next;
                        byte_reg  <= byte_next;
                        if (emits)
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= kind_next;
                            slot_reg      <= slot_next;
                            len_reg       <= len_next;
                            csum_reg      <= csum_next;
                            irq_reg       <= irq_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_kind    = kind_reg;
    assign rsp.slot_index     = slot_reg;
    assign rsp.length_out     = len_reg;
    assign rsp.checksum_valid = csum_reg;
    assign rsp.rx_interrupt   = irq_reg;
    assign rsp.dropped_total  = drop_reg;
    assign rsp.packets_total  = pkt_reg;
    assign rsp.bytes_total    = byte_reg;

endmodule

/* hdl/rxr_checker.sv */
module rxr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [rxr_pkg::KIND_W-1:0]  result_kind,
    input logic [rxr_pkg::LEN_W-1:0]   length_out,
    input logic                        checksum_valid,
    input logic                        rx_interrupt
);

    // One item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("accept while busy");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result dropped under stall");

    a_delivered_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && result_kind == rxr_pkg::KIND_DELIVERED)
            |-> (rx_interrupt && checksum_valid))
        else $error("delivered without interrupt or checksum");

    a_irq_only_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rx_interrupt) |-> (result_kind == rxr_pkg::KIND_DELIVERED))
        else $error("interrupt on non-deliver result");

    a_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (result_kind == rxr_pkg::KIND_DROPPED
                    || result_kind == rxr_pkg::KIND_POSTED
                    || result_kind == rxr_pkg::KIND_EMPTY))
            |-> (length_out == '0 && !checksum_valid))
        else $error("length on result without a frame");

endmodule

bind rx_descriptor_ring rxr_checker u_rxr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .result_kind    (rsp.result_kind),
    .length_out     (rsp.length_out),
    .checksum_valid (rsp.checksum_valid),
    .rx_interrupt   (rsp.rx_interrupt)
);
